### sv/edge_non_max_suppression_macros.svh
// Assertion shorthands for edge_non_max_suppression.sv, which checks its own logic.
// Every property is sampled on the rising edge of clk and is switched off in reset.
`ifndef EDGE_NON_MAX_SUPPRESSION_MACROS_SVH
`define EDGE_NON_MAX_SUPPRESSION_MACROS_SVH

// The condition holds on every clock edge.
`define ENMS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Whenever ante holds, cons holds on the same edge.
`define ENMS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Whenever ante holds, cons holds on the following edge.
`define ENMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/enms_pkg.sv
package enms_pkg;

  localparam int MAX_WIDTH_DEFAULT = 1024;
  localparam int MAG_BITS_DEFAULT  = 16;

  localparam int MIN_SIZE      = 3;
  localparam int WIDTH_RESET   = 640;
  localparam int HEIGHT_RESET  = 480;
  localparam int Q_QUARTER_PI  = 6434;
  localparam int Q_HALF_PI     = 12868;

  // Configuration port.
  localparam int ADDR_BITS = 3;
  localparam logic [ADDR_BITS-3:0] REG_WIDTH  = 1'b0;
  localparam logic [ADDR_BITS-3:0] REG_HEIGHT = 1'b1;

  // Result queue.
  localparam int OUT_DEPTH  = 4;
  localparam int PTR_BITS   = $clog2(OUT_DEPTH);
  localparam int LEVEL_BITS = $clog2(OUT_DEPTH + 1);

  // Gradient direction codes.
  localparam logic [1:0] DIR_OTHER  = 2'd0;
  localparam logic [1:0] DIR_STEEP  = 2'd1;
  localparam logic [1:0] DIR_RISING = 2'd2;
  localparam logic [1:0] DIR_FLAT   = 2'd3;

  typedef struct packed {
    logic [15:0]        magnitude_in;
    logic signed [15:0] angle_in;
    logic               frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] edge_out;
    logic [9:0]  out_col;
    logic [15:0] out_row;
  } pix_out_t;

  // Position and flags of the centre pixel, passed from the line store to the window.
  typedef struct packed {
    logic        emit;
    logic        border;
    logic [9:0]  col;
    logic [15:0] row;
  } enms_tag_t;

  function automatic logic [1:0] angle_code(input logic signed [15:0] a);
    logic [1:0] code;
    if (a > Q_QUARTER_PI && a <= Q_HALF_PI) begin
      code = DIR_STEEP;
    end else if (a > 0 && a <= Q_QUARTER_PI) begin
      code = DIR_RISING;
    end else if (a > -Q_QUARTER_PI && a <= 0) begin
      code = DIR_FLAT;
    end else begin
      code = DIR_OTHER;
    end
    return code;
  endfunction

endpackage

### sv/edge_non_max_suppression.sv
// Non-maximum suppression for a Canny edge stream, 3x3 neighbourhood.
// Input channel pix_valid/pix_ready/pix_data carries one word per pixel in raster
// order: gradient magnitude, gradient angle (Q3.13 radians) and a frame start mark.
// Output channel res_valid/res_ready/res_data carries the suppressed magnitude and
// the column and row of the pixel it belongs to, width+1 pixels behind the input.
// A result word passes the line store stage, the window register and the result queue
// before it is offered; the last width+1 pixels of a frame, all border zeros, never produce a word.
// Throughput is one pixel per clock while pix_ready is high: the line store has one read
// and one write port, and each pixel reads its column once and writes it back once.
// Frame size is to be set over the APB-style port (width at 0x0, height at 0x4) while idle;
// the block does not enforce it. After reset the block sweeps the line store to zero,
// one entry per cycle, and takes no pixels until the sweep ends; configuration writes are taken throughout.
// When the receiver stalls, results collect in a four-word queue and pix_ready
// falls once the queue plus the words still in the pipeline could fill it.
`include "edge_non_max_suppression_macros.svh"

module edge_non_max_suppression
  import enms_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  parameter int MAG_BITS  = MAG_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_ready,
  input  pix_in_t              pix_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output pix_out_t             res_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int WBITS     = $clog2(MAX_WIDTH + 1);
  localparam int WORD_BITS = 2 * MAG_BITS + 2;

  // Configuration registers.
  logic [10:0]          image_width;
  logic [15:0]          image_height;
  logic [ADDR_BITS-3:0] reg_sel;
  logic                 cfg_write;
  logic [WBITS-1:0]     w_eff;
  logic [15:0]          h_eff;

  // Position counters and the address of the incoming pixel.
  logic [COL_BITS-1:0] column_count, column_count_next;
  logic [15:0]         row_count, row_count_next;
  logic [COL_BITS-1:0] c0, c_cur;
  logic [15:0]         r0, r_cur;
  logic [16:0]         r1, r_inc;
  logic [WBITS-1:0]    c_inc;
  logic                pix_fire;

  // Clearing sweep.
  logic [COL_BITS-1:0] clr_addr;
  logic                clear_done;

  // Line store stage.
  logic                 s1_valid;
  logic [COL_BITS-1:0]  s1_c;
  logic [15:0]          s1_r;
  logic [MAG_BITS-1:0]  s1_cur;
  logic [1:0]           s1_code;
  logic                 fwd_hit;
  logic [WORD_BITS-1:0] fwd_data;
  logic [WORD_BITS-1:0] ram_rdata, rd_word, wdata;
  logic [COL_BITS-1:0]  waddr;
  logic                 we;
  logic [MAG_BITS-1:0]  up, mid;
  logic [1:0]           mid_code;
  logic [WBITS-1:0]     oc;
  logic [15:0]          orow;
  enms_tag_t            tag;

  // Result path.
  logic                  win_valid;
  pix_out_t              win_res;
  logic [LEVEL_BITS-1:0] level;
  logic [LEVEL_BITS:0]   credit_sum;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready stays high.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_sel   = paddr[ADDR_BITS-1:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'(WIDTH_RESET);
      image_height <= 16'(HEIGHT_RESET);
    end else if (cfg_write) begin
      case (reg_sel)
        REG_WIDTH:  image_width  <= pwdata[10:0];
        REG_HEIGHT: image_height <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      default:    prdata = '0;
    endcase
  end

  // The working frame size is the programmed size held inside its legal range.
  always_comb begin
    if (image_width < 11'(MIN_SIZE)) begin
      w_eff = WBITS'(MIN_SIZE);
    end else if (image_width > MAX_WIDTH) begin
      w_eff = WBITS'(MAX_WIDTH);
    end else begin
      w_eff = WBITS'(image_width);
    end
  end

  assign h_eff = (image_height < 16'(MIN_SIZE)) ? 16'(MIN_SIZE) : image_height;

  // ---------------------------------------------------------------------------
  // Raster position of the incoming pixel. A frame start mark restarts the
  // count; a column beyond the row (after a width change) folds into the next
  // row, and a row beyond the frame folds to zero.
  // ---------------------------------------------------------------------------
  assign pix_fire = pix_valid && pix_ready;

  always_comb begin
    c0 = pix_data.frame_start ? '0 : column_count;
    r0 = pix_data.frame_start ? '0 : row_count;
    if (WBITS'(c0) >= w_eff) begin
      c_cur = '0;
      r1    = 17'(r0) + 17'd1;
    end else begin
      c_cur = c0;
      r1    = 17'(r0);
    end
    r_cur = (r1 >= 17'(h_eff)) ? 16'd0 : r1[15:0];

    c_inc = WBITS'(c_cur) + WBITS'(1);
    r_inc = 17'(r_cur) + 17'd1;
    if (c_inc >= w_eff) begin
      column_count_next = '0;
      row_count_next    = (r_inc >= 17'(h_eff)) ? 16'd0 : r_inc[15:0];
    end else begin
      column_count_next = c_inc[COL_BITS-1:0];
      row_count_next    = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (pix_fire) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store. One word per column holds the magnitude two rows up, the
  // magnitude one row up and the direction code one row up. The word is read
  // when the pixel is accepted and written back in the next cycle.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      clear_done <= 1'b0;
    end else if (!clear_done) begin
      if (clr_addr == COL_BITS'(MAX_WIDTH - 1)) begin
        clear_done <= 1'b1;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  enms_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (c_cur),
    .rdata (ram_rdata)
  );

  // A pixel that reads the column its predecessor is writing back in the same
  // cycle (a repeated frame start) takes the written word instead of the memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= pix_fire;
      fwd_hit  <= pix_fire && s1_valid && (s1_c == c_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      s1_c     <= c_cur;
      s1_r     <= r_cur;
      s1_cur   <= MAG_BITS'(pix_data.magnitude_in);
      s1_code  <= angle_code(pix_data.angle_in);
      fwd_data <= wdata;
    end
  end

  assign rd_word  = fwd_hit ? fwd_data : ram_rdata;
  assign up       = rd_word[WORD_BITS-1 -: MAG_BITS];
  assign mid      = rd_word[MAG_BITS+1 -: MAG_BITS];
  assign mid_code = rd_word[1:0];

  assign we    = !clear_done || s1_valid;
  assign waddr = clear_done ? s1_c : clr_addr;
  assign wdata = clear_done ? {mid, s1_cur, s1_code} : '0;

  // The window centre sits one row and one column behind the incoming pixel.
  always_comb begin
    if (s1_c != '0) begin
      oc   = WBITS'(s1_c) - WBITS'(1);
      orow = s1_r - 16'd1;
    end else begin
      oc   = w_eff - WBITS'(1);
      orow = s1_r - 16'd2;
    end
    tag.emit   = (s1_r >= 16'd2) || ((s1_r == 16'd1) && (s1_c != '0));
    tag.border = (oc == '0) || (oc == w_eff - WBITS'(1)) ||
                 (orow == 16'd0) || (orow == h_eff - 16'd1);
    tag.col    = 10'(oc);
    tag.row    = orow;
  end

  // ---------------------------------------------------------------------------
  // Window, direction test and result queue.
  // ---------------------------------------------------------------------------
  enms_window #(
    .MAG_BITS (MAG_BITS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .shift     (s1_valid),
    .up        (up),
    .mid       (mid),
    .cur       (s1_cur),
    .mid_code  (mid_code),
    .tag       (tag),
    .res_valid (win_valid),
    .res       (win_res)
  );

  enms_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (win_valid),
    .push_data (win_res),
    .pop_ready (res_ready),
    .out_valid (res_valid),
    .out_data  (res_data),
    .level     (level)
  );

  // Every word still in the pipeline is counted against the queue, so a
  // stalled receiver never loses a result.
  assign credit_sum = (LEVEL_BITS+1)'(level) + (LEVEL_BITS+1)'(s1_valid) +
                      (LEVEL_BITS+1)'(win_valid);
  assign pix_ready  = clear_done && (credit_sum < (LEVEL_BITS+1)'(OUT_DEPTH));

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  `ENMS_ASSERT_IMPLIES(a_no_pixel_in_sweep, !clear_done, !pix_ready, "pixel taken during clear")
  `ENMS_ASSERT_ALWAYS(a_queue_credit, credit_sum <= (LEVEL_BITS+1)'(OUT_DEPTH), "queue overbooked")
  `ENMS_ASSERT_IMPLIES(a_forward_follows, fwd_hit, s1_valid, "forward without a pixel")
  `ENMS_ASSERT_NEXT(a_sweep_once, clear_done, clear_done, "clear sweep restarted")

endmodule

### sv/enms_ram.sv
module enms_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/enms_window.sv
module enms_window
  import enms_pkg::*;
#(
  parameter int MAG_BITS = MAG_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic [MAG_BITS-1:0] up,
  input  logic [MAG_BITS-1:0] mid,
  input  logic [MAG_BITS-1:0] cur,
  input  logic [1:0]          mid_code,
  input  enms_tag_t           tag,
  output logic                res_valid,
  output pix_out_t            res
);

  logic [MAG_BITS-1:0] win [9];
  logic [1:0]          code_d [2];
  enms_tag_t           s2_tag;
  logic                s2_valid;
  logic [MAG_BITS-1:0] centre;
  logic                vert, diag_down, horiz, diag_up, keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
      code_d[0] <= DIR_OTHER;
      code_d[1] <= DIR_OTHER;
      s2_valid  <= 1'b0;
    end else begin
      s2_valid <= shift && tag.emit;
      if (shift) begin
        for (int i = 0; i < 3; i++) begin
          win[i*3]     <= win[i*3 + 1];
          win[i*3 + 1] <= win[i*3 + 2];
        end
        win[2]    <= up;
        win[5]    <= mid;
        win[8]    <= cur;
        code_d[0] <= mid_code;
        code_d[1] <= code_d[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      s2_tag <= tag;
    end
  end

  // Each pair test: both neighbours strictly below the centre.
  assign centre    = win[4];
  assign vert      = (win[1] < centre) && (win[7] < centre);
  assign diag_down = (win[8] < centre) && (win[0] < centre);
  assign horiz     = (win[5] < centre) && (win[3] < centre);
  assign diag_up   = (win[2] < centre) && (win[6] < centre);

  always_comb begin
    case (code_d[1])
      DIR_STEEP:  keep = vert || diag_down;
      DIR_RISING: keep = diag_down || horiz;
      DIR_FLAT:   keep = horiz || diag_up;
      default:    keep = diag_up || vert;
    endcase
  end

  assign res_valid    = s2_valid;
  assign res.edge_out = (keep && !s2_tag.border) ? 16'(centre) : 16'd0;
  assign res.out_col  = s2_tag.col;
  assign res.out_row  = s2_tag.row;

endmodule

### sv/enms_out_fifo.sv
module enms_out_fifo
  import enms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pix_out_t              push_data,
  input  logic                  pop_ready,
  output logic                  out_valid,
  output pix_out_t              out_data,
  output logic [LEVEL_BITS-1:0] level
);

  pix_out_t            slots [OUT_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic                pop;

  assign out_valid = (level != '0);
  assign out_data  = slots[rd_ptr];
  assign pop       = out_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### tb/tb_edge_non_max_suppression.sv
`timescale 1ns / 1ps

module tb_edge_non_max_suppression;
  import enms_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int LINE_DEPTH     = MAX_WIDTH_DEFAULT;
  localparam int ANGLE_PI       = 25736;
  // Results pass the line store stage, the window register and the result queue after the
  // word that completes their window, so this settling wait is ample before the block can be taken as idle.
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 200;
  // The longest correct stretch without a handshake is the line store sweep after
  // reset or the long receiver hold-off, so four times their sum is a safe limit.
  localparam int WATCHDOG_LIMIT = 4 * (LINE_DEPTH + LONG_HOLD);
  localparam int WIDE_ITEMS     = 200;
  localparam int RANDOM_ITEMS   = 300;
  localparam int CALM_ITEMS     = 100;
  localparam int SHOWN_LIMIT    = 10;
  localparam logic [ADDR_BITS-1:0] WIDTH_ADDR  = {REG_WIDTH, 2'b00};
  localparam logic [ADDR_BITS-1:0] HEIGHT_ADDR = {REG_HEIGHT, 2'b00};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pix_valid = 1'b0;
  logic                 pix_ready;
  pix_in_t              pix_data = '0;
  logic                 res_valid;
  logic                 res_ready;
  pix_out_t             res_data;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // Idling is switched off for the last part of the run; the receiver hold-off is
  // requested by the test sequence and carried out by the receiver process.
  bit calm = 1'b0;
  bit hold_wanted = 1'b0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // Shadow copy of the block's state, advanced once per accepted pixel word.
  logic [10:0] cfg_width;
  logic [15:0] cfg_height;
  logic [15:0] row_above [LINE_DEPTH];
  logic [15:0] row_mid [LINE_DEPTH];
  logic [1:0]  mid_dirs [LINE_DEPTH];
  // 3x3 magnitudes: index 3*(dy+1) + (dx+1), top row first, newest column on the right.
  logic [15:0] win [9];
  logic [1:0]  dir_delay [2];
  int          next_col;
  int          next_row;

  // Suppressed magnitudes and positions still owed by the block, oldest first.
  pix_out_t pending_edges [$];

  edge_non_max_suppression DUT (
    .clk      (clk),
    .rst      (rst),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix_data (pix_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Quantises a Q3.13 angle into the gradient direction that picks the neighbour pairs.
  function automatic logic [1:0] gradient_dir(input logic signed [15:0] angle);
    int a;
    a = angle;
    if (a <= -Q_QUARTER_PI || a > Q_HALF_PI) return DIR_OTHER;
    if (a <= 0) return DIR_FLAT;
    if (a <= Q_QUARTER_PI) return DIR_RISING;
    return DIR_STEEP;
  endfunction

  // The centre survives when it is strictly above both members of either pair
  // that its direction selects.
  function automatic logic is_local_max(input logic [1:0] dir);
    logic [15:0] t;
    t = win[4];
    case (dir)
      DIR_STEEP:  return (win[1] < t && win[7] < t) || (win[8] < t && win[0] < t);
      DIR_RISING: return (win[8] < t && win[0] < t) || (win[5] < t && win[3] < t);
      DIR_FLAT:   return (win[5] < t && win[3] < t) || (win[2] < t && win[6] < t);
      default:    return (win[2] < t && win[6] < t) || (win[1] < t && win[7] < t);
    endcase
  endfunction

  // Advances the shadow state by one pixel and queues the result word it releases.
  task automatic predict_pixel(input pix_in_t px);
    int w, h, c, r, oc, orow, i;
    logic [1:0] centre_dir;
    pix_out_t res;
    w = cfg_width;
    h = cfg_height;
    if (w < MIN_SIZE) w = MIN_SIZE;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    if (h < MIN_SIZE) h = MIN_SIZE;
    c = next_col;
    r = next_row;
    if (px.frame_start) begin
      c = 0;
      r = 0;
    end
    // A position left outside the frame by a size change folds back inside it.
    if (c >= w) begin
      c = 0;
      r = r + 1;
    end
    if (r >= h) r = 0;

    for (i = 0; i < 3; i++) begin
      win[3*i]     = win[3*i + 1];
      win[3*i + 1] = win[3*i + 2];
    end
    win[2] = row_above[c];
    win[5] = row_mid[c];
    win[8] = px.magnitude_in;
    dir_delay[1] = dir_delay[0];
    dir_delay[0] = mid_dirs[c];
    centre_dir = dir_delay[1];
    row_above[c] = row_mid[c];
    row_mid[c] = px.magnitude_in;
    mid_dirs[c] = gradient_dir(px.angle_in);

    // Without a frame mark the row count simply wraps after the last row.
    next_col = c + 1;
    next_row = r;
    if (next_col >= w) begin
      next_col = 0;
      next_row = (r + 1 >= h) ? 0 : r + 1;
    end

    // Nothing comes out until the window centre has entered the frame.
    if (r >= 2 || (r == 1 && c >= 1)) begin
      if (c >= 1) begin
        oc = c - 1;
        orow = r - 1;
      end else begin
        oc = w - 1;
        orow = r - 2;
      end
      res.edge_out = '0;
      if (oc != 0 && oc != w - 1 && orow != 0 && orow != h - 1 && is_local_max(centre_dir))
        res.edge_out = win[4];
      res.out_col = 10'(oc);
      res.out_row = 16'(orow);
      pending_edges.push_back(res);
    end
  endtask

  // Offers one pixel word, keeping valid high across back-to-back words and
  // dropping it only for a random gap, then waits for the handshake.
  task automatic send_pixel(input pix_in_t px);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      pix_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_valid <= 1'b1;
    pix_data <= px;
    do @(posedge clk); while (!pix_ready);
    predict_pixel(px);
  endtask

  // Stops offering words and waits until every owed result has been taken, plus
  // the pipeline latency, so that the block is idle afterwards.
  task automatic drain_results();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup phase, then access phase; the register is written at the access edge.
  task automatic write_reg(input logic [ADDR_BITS-1:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == WIDTH_ADDR) cfg_width = value[10:0];
    else if (addr == HEIGHT_ADDR) cfg_height = value[15:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Magnitudes lean towards ties and extremes; angles often sit on a quantiser boundary.
  function automatic pix_in_t random_pixel(input logic mark);
    pix_in_t px;
    int a;
    case ($urandom_range(0, 3))
      0: px.magnitude_in = 16'($urandom_range(0, 3));
      1: px.magnitude_in = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: px.magnitude_in = 16'($urandom);
    endcase
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 3))
        0: a = Q_QUARTER_PI;
        1: a = Q_HALF_PI;
        2: a = 0;
        default: a = ANGLE_PI;
      endcase
      if (a != ANGLE_PI) a = a + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1)) a = -a;
    end else begin
      a = int'($urandom_range(0, 2 * ANGLE_PI)) - ANGLE_PI;
    end
    px.angle_in = 16'(a);
    px.frame_start = mark;
    return px;
  endfunction

  // A 4x4 frame whose four inner pixels take one direction each, with angles on
  // the quantiser boundaries, magnitude extremes and a tie with a neighbour.
  task automatic test_directions();
    int mags [16] = '{10, 65535, 0, 20,
                      0, 65535, 40000, 7,
                      65535, 300, 300, 1,
                      5, 0, 65535, 299};
    int angs [16] = '{-ANGLE_PI, ANGLE_PI, 12869, 6435,
                      1, Q_HALF_PI, Q_QUARTER_PI, -6433,
                      -1, 0, -Q_QUARTER_PI, -Q_HALF_PI,
                      -12869, 100, -100, 25000};
    pix_in_t px;
    drain_results();
    write_reg(WIDTH_ADDR, 32'd4);
    write_reg(HEIGHT_ADDR, 32'd4);
    for (int i = 0; i < 16; i++) begin
      px.magnitude_in = 16'(mags[i]);
      px.angle_in = 16'(angs[i]);
      px.frame_start = (i == 0);
      send_pixel(px);
    end
  endtask

  // Sizes below the minimum are raised to a 3x3 frame.
  task automatic test_size_clamping();
    drain_results();
    write_reg(WIDTH_ADDR, 32'd1);
    write_reg(HEIGHT_ADDR, 32'd2);
    for (int i = 0; i < 9; i++) send_pixel(random_pixel(i == 0));
  endtask

  // All-ones register values: the width is capped at the line store depth and the
  // height is the largest the field holds. Only the start of the first row is sent.
  task automatic test_widest_line();
    drain_results();
    write_reg(WIDTH_ADDR, 32'hFFFF_FFFF);
    write_reg(HEIGHT_ADDR, 32'hFFFF_FFFF);
    for (int i = 0; i < WIDE_ITEMS; i++) send_pixel(random_pixel(i == 0));
  endtask

  // Narrowing the frame in mid-row leaves the column outside it, so the next
  // pixel folds to the start of the following row.
  task automatic test_resize_midframe();
    drain_results();
    write_reg(WIDTH_ADDR, 32'd5);
    write_reg(HEIGHT_ADDR, 32'd4);
    for (int i = 0; i < 30; i++) send_pixel(random_pixel(1'b0));
  endtask

  // The receiver holds off while the sender keeps offering, so the result queue
  // fills and the input stalls. Afterwards the frame is made shorter than the
  // current row, which folds the row count back to zero.
  task automatic test_receiver_hold();
    drain_results();
    write_reg(WIDTH_ADDR, 32'd4);
    write_reg(HEIGHT_ADDR, 32'd8);
    @(posedge clk);
    hold_wanted = 1'b1;
    for (int i = 0; i < 26; i++) send_pixel(random_pixel(i == 0));
    drain_results();
    write_reg(HEIGHT_ADDR, 32'd3);
    for (int i = 0; i < 12; i++) send_pixel(random_pixel(1'b0));
  endtask

  // Mostly whole frames of random small sizes; some are cut short, some carry no
  // frame mark, some run past their last row and some get a mark part-way through.
  task automatic test_random_frames();
    int sent, w, h, fw, fh, kind, n, cut, i;
    logic [31:0] word;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent + CALM_ITEMS >= RANDOM_ITEMS);
      if (sent == 0 || $urandom_range(0, 2) == 0) begin
        drain_results();
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
        word = $urandom;
        word[10:0] = 11'(w);
        write_reg(WIDTH_ADDR, word);
        word = $urandom;
        word[15:0] = 16'(h);
        write_reg(HEIGHT_ADDR, word);
        fw = (w < MIN_SIZE) ? MIN_SIZE : w;
        fh = (h < MIN_SIZE) ? MIN_SIZE : h;
      end
      kind = $urandom_range(0, 7);
      n = fw * fh;
      cut = $urandom_range(1, n - 1);
      if (kind == 0) n = cut;
      else if (kind == 1) n = n + fw * $urandom_range(1, fh);
      for (i = 0; i < n; i++)
        send_pixel(random_pixel((i == 0 && kind != 2) || (kind == 3 && i == cut)));
      sent = sent + n;
    end
  endtask

  // Receiver: random stall bursts, the long hold-off on request, always ready when calm.
  initial begin : result_receiver
    int gap;
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        res_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 9);
        res_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Each accepted result word is compared field by field with the oldest one owed.
  always @(posedge clk) begin
    pix_out_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_edges.size() == 0) begin
        if (mismatches < SHOWN_LIMIT)
          $display("%0t: unexpected result word: edge %0d col %0d row %0d", $realtime,
                   res_data.edge_out, res_data.out_col, res_data.out_row);
        mismatches++;
      end else begin
        want = pending_edges.pop_front();
        if (res_data.edge_out !== want.edge_out || res_data.out_col !== want.out_col ||
            res_data.out_row !== want.out_row) begin
          if (mismatches < SHOWN_LIMIT)
            $display("%0t: want edge %0d col %0d row %0d, got edge %0d col %0d row %0d",
                     $realtime, want.edge_out, want.out_col, want.out_row,
                     res_data.edge_out, res_data.out_col, res_data.out_row);
          mismatches++;
        end
      end
    end
  end

  // Ends the run when no word has moved on either channel for too long.
  always @(posedge clk) begin
    if ((pix_valid && pix_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no word accepted for %0d cycles, %0d results owed",
               WATCHDOG_LIMIT, pending_edges.size());
      $display("FAIL edge_non_max_suppression");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Shadow state starts as the block does after reset.
    cfg_width = 11'(WIDTH_RESET);
    cfg_height = 16'(HEIGHT_RESET);
    for (int i = 0; i < LINE_DEPTH; i++) begin
      row_above[i] = '0;
      row_mid[i] = '0;
      mid_dirs[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    dir_delay[0] = '0;
    dir_delay[1] = '0;
    next_col = 0;
    next_row = 0;

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    test_directions();
    test_size_clamping();
    test_widest_line();
    test_resize_midframe();
    test_receiver_hold();
    test_random_frames();
    drain_results();

    if (mismatches == 0) begin
      $display("PASS edge_non_max_suppression");
    end else begin
      $display("FAIL edge_non_max_suppression");
    end
    $finish;
  end

endmodule
